// ===== rtl/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and fixed-point constants for the skin color pixel classifier.
// ----------------------------------------------------------------------------
package scp_pkg;

  typedef enum logic {
    RULE_SET_FIRST  = 1'b0,
    RULE_SET_SECOND = 1'b1
  } rule_set_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] chroma_red;
    logic [7:0] chroma_blue;
    logic [7:0] hue;
    logic [7:0] saturation;
  } pixel_t;

  localparam int BOUND_W = 27;
  typedef logic signed [BOUND_W-1:0] bound_t;

  localparam bound_t LINE_SCALE = 27'sd10000;

  localparam bound_t UP_SLOPE   = 27'sd15862;
  localparam bound_t UP_OFFSET  = 27'sd200000;
  localparam bound_t LO1_SLOPE  = 27'sd3448;
  localparam bound_t LO1_OFFSET = 27'sd762069;
  localparam bound_t LO2_SLOPE  = -27'sd45652;
  localparam bound_t LO2_OFFSET = 27'sd2345652;
  localparam bound_t HI1_SLOPE  = -27'sd11500;
  localparam bound_t HI1_OFFSET = 27'sd3017500;
  localparam bound_t HI2_SLOPE  = -27'sd22857;
  localparam bound_t HI2_OFFSET = 27'sd4328500;

  localparam logic [7:0] DAY_RED_MIN   = 8'd95;
  localparam logic [7:0] DAY_GREEN_MIN = 8'd40;
  localparam logic [7:0] DAY_BLUE_MIN  = 8'd20;
  localparam logic [8:0] RGB_SPREAD    = 9'd15;
  localparam logic [7:0] FL_RED_MIN    = 8'd220;
  localparam logic [7:0] FL_GREEN_MIN  = 8'd210;
  localparam logic [7:0] FL_BLUE_MIN   = 8'd170;

  localparam logic [7:0] HUE_LOW_LIM   = 8'd18;
  localparam logic [7:0] HUE_HIGH_LIM  = 8'd161;
  localparam logic [7:0] HUE_MAX_SET1  = 8'd25;
  localparam logic [7:0] SAT_MIN       = 8'd59;
  localparam logic [7:0] SAT_MAX       = 8'd173;
  localparam logic [7:0] CR_MIN_SET1   = 8'd135;
  localparam logic [7:0] CB_MIN_SET1   = 8'd85;

endpackage

// ===== rtl/skin_color_pixel_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// skin_color_pixel_classifier_unit
// Two-register pipeline that flags each pixel as skin or not.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one pixel: red, green, blue,
//   chroma_red, chroma_blue, hue, saturation. Output channel
//   (out_valid/out_ready) carries the one-bit is_skin flag per pixel, in
//   order. The config channel (cfg_valid/cfg_ready, cfg_data) writes the
//   rule set select; cfg_ready is always high, and a write is applied on
//   the next edge. Write it only while no pixel is in flight.
//   Path: a transferred pixel lands in the input register, then its flag
//   is captured in the result register once that register can advance.
//   Throughput: one pixel per cycle while out_ready is high; the rule logic
//   between the input register and the result register is combinational.
//   Stall: when out_ready is low, a full result register holds, the input
//   register holds if both are full, and in_ready drops once both are full.
//   Reset: both registers empty, rule set 0 selected.
// ----------------------------------------------------------------------------
module skin_color_pixel_classifier_unit
  import scp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] chroma_red,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_skin,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  rule_set_t rule_set;
  pixel_t    px;
  logic      px_valid;
  logic      px_adv;
  logic      skin;

  assign cfg_ready = 1'b1;
  assign px_adv    = !out_valid || out_ready;
  assign in_ready  = !px_valid || px_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_set <= RULE_SET_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      rule_set <= rule_set_t'(cfg_data);
    end
  end

  // hold the pixel until the result register can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      px_valid <= 1'b0;
    end else if (in_ready) begin
      px_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      px <= '{red: red, green: green, blue: blue, chroma_red: chroma_red,
              chroma_blue: chroma_blue, hue: hue, saturation: saturation};
    end
  end

  scp_rules u_rules (
    .px       (px),
    .rule_set (rule_set),
    .skin     (skin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (px_adv) begin
      out_valid <= px_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (px_adv && px_valid) begin
      is_skin <= skin;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !px_valid)
    else $error("pipeline not empty after reset");

  a_in_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> px_valid)
    else $error("transferred pixel lost at input register");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    px_valid && px_adv |=> out_valid)
    else $error("pixel advanced without a result");

  a_hold_px: assert property (@(posedge clk) disable iff (rst)
    px_valid && !px_adv |=> px_valid && $stable(px))
    else $error("stalled pixel changed");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> rule_set == rule_set_t'($past(cfg_data)))
    else $error("rule set write not applied");

endmodule

// ===== rtl/scp_rules.sv =====
// ----------------------------------------------------------------------------
// scp_rules
// Combinational skin rules: RGB tests, Cr/Cb line bounds and hue/saturation
// window, combined according to the selected rule set.
// ----------------------------------------------------------------------------
module scp_rules
  import scp_pkg::*;
(
  input  pixel_t    px,
  input  rule_set_t rule_set,
  output logic      skin
);

  logic [8:0] rg_diff;
  logic [7:0] mx;
  logic [7:0] mn;
  logic       r_gt_g;
  logic       r_gt_b;
  logic       g_gt_b;
  logic       daylight;
  logic       flash;
  logic       red_dom;

  bound_t cr_s;
  bound_t cb_s;
  bound_t y;
  logic   up_ok;
  logic   lo1_ok;
  logic   lo2_ok;
  logic   hi1_ok;
  logic   hi2_ok;
  logic   four_ok;

  logic   hue_set0;
  logic   alt_hs;
  logic   alt_crcb;

  assign r_gt_g = px.red > px.green;
  assign r_gt_b = px.red > px.blue;
  assign g_gt_b = px.green > px.blue;

  assign rg_diff = r_gt_g ? ({1'b0, px.red} - {1'b0, px.green})
                          : ({1'b0, px.green} - {1'b0, px.red});

  always_comb begin
    mx = px.red;
    mn = px.red;
    if (px.green > mx) mx = px.green;
    if (px.blue > mx)  mx = px.blue;
    if (px.green < mn) mn = px.green;
    if (px.blue < mn)  mn = px.blue;
  end

  assign red_dom  = (px.red > DAY_RED_MIN) && (px.green > DAY_GREEN_MIN) &&
                    (px.blue > DAY_BLUE_MIN) && (rg_diff > RGB_SPREAD) &&
                    r_gt_g && r_gt_b;
  assign daylight = red_dom && (({1'b0, mx} - {1'b0, mn}) > RGB_SPREAD);
  assign flash    = (px.red > FL_RED_MIN) && (px.green > FL_GREEN_MIN) &&
                    (px.blue > FL_BLUE_MIN) && (rg_diff <= RGB_SPREAD) &&
                    r_gt_b && g_gt_b;

  assign cr_s = bound_t'({1'b0, px.chroma_red});
  assign cb_s = bound_t'({1'b0, px.chroma_blue});
  assign y    = cr_s * LINE_SCALE;

  assign up_ok  = y <= (UP_SLOPE  * cb_s + UP_OFFSET);
  assign lo1_ok = y >= (LO1_SLOPE * cb_s + LO1_OFFSET);
  assign lo2_ok = y >= (LO2_SLOPE * cb_s + LO2_OFFSET);
  assign hi1_ok = y <= (HI1_SLOPE * cb_s + HI1_OFFSET);
  assign hi2_ok = y <= (HI2_SLOPE * cb_s + HI2_OFFSET);
  assign four_ok = lo1_ok && lo2_ok && hi1_ok && hi2_ok;

  assign hue_set0 = (px.hue < HUE_LOW_LIM) || (px.hue > HUE_HIGH_LIM);
  assign alt_hs   = (px.hue <= HUE_MAX_SET1) && (px.saturation >= SAT_MIN) &&
                    (px.saturation <= SAT_MAX);
  assign alt_crcb = (px.chroma_red > CR_MIN_SET1) &&
                    (px.chroma_blue > CB_MIN_SET1) && four_ok;

  always_comb begin
    unique case (rule_set)
      RULE_SET_FIRST:  skin = (daylight || flash) && up_ok && four_ok && hue_set0;
      RULE_SET_SECOND: skin = red_dom && (alt_hs || alt_crcb);
      default:         skin = 1'b0;
    endcase
  end

endmodule
